>>> design/planar_odometry_integrator_defines.svh
// Assertion macros shared by the checker files of the pose integrator.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_DEFINES_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define POI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define POI_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/poi_pkg.sv
// Shared types, constants and the CORDIC arctan table of the pose integrator.
`timescale 1ns / 1ps
`default_nettype none

package poi_pkg;

	// Field widths
	localparam int V_W    = 16;            // speed and rate magnitude
	localparam int DT_W   = 16;            // step time
	localparam int POS_W  = 32;            // position
	localparam int HDG_W  = 16;            // binary angle
	localparam int IN_W   = 3 * V_W;       // slave tdata
	localparam int OUT_W  = 2 * POS_W + HDG_W;

	// CORDIC datapath: Q2.30 with headroom
	localparam int CW        = 34;
	localparam int TABLE_LEN = 24;
	localparam int IDX_W     = $clog2(TABLE_LEN);

	// Second multiply pass: operand width of the serial lanes
	localparam int MB_W = 32;

	localparam logic signed [CW-1:0] GAIN_INV_Q30   = 34'sd652032874;
	localparam logic signed [CW-1:0] TWO_PI_Q30     = 34'sd6746518852;
	localparam logic [MB_W-1:0]      RAD_TO_BAM_Q32 = 32'd683565276;

	// Load / step strobes for a sequenced unit
	typedef struct packed {
		logic load;
		logic step;
	} seq_ctl_t;

	// atan(2^-i) in Q2.30
	function automatic logic signed [CW-1:0] atan_q30(input logic [IDX_W-1:0] idx);
		logic signed [CW-1:0] v;
		begin
			case (idx)
				5'd0:    v = 34'sd843314857;
				5'd1:    v = 34'sd497837829;
				5'd2:    v = 34'sd263043837;
				5'd3:    v = 34'sd133525159;
				5'd4:    v = 34'sd67021687;
				5'd5:    v = 34'sd33543516;
				5'd6:    v = 34'sd16775851;
				5'd7:    v = 34'sd8388437;
				5'd8:    v = 34'sd4194283;
				5'd9:    v = 34'sd2097149;
				5'd10:   v = 34'sd1048576;
				5'd11:   v = 34'sd524288;
				5'd12:   v = 34'sd262144;
				5'd13:   v = 34'sd131072;
				5'd14:   v = 34'sd65536;
				5'd15:   v = 34'sd32768;
				5'd16:   v = 34'sd16384;
				5'd17:   v = 34'sd8192;
				5'd18:   v = 34'sd4096;
				5'd19:   v = 34'sd2048;
				5'd20:   v = 34'sd1024;
				5'd21:   v = 34'sd512;
				5'd22:   v = 34'sd256;
				5'd23:   v = 34'sd128;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

`default_nettype wire

>>> design/poi_smul.sv
// Serial-parallel unsigned multiplier: one multiplier bit per cycle while step is set, LSB first.
`timescale 1ns / 1ps
`default_nettype none

module poi_smul import poi_pkg::*; #(
	parameter int A_W = 16,
	parameter int B_W = 16
) (
	input  wire logic             clk,
	input  wire seq_ctl_t         ctl,
	input  wire logic [A_W-1:0]   a,
	input  wire logic [B_W-1:0]   b,
	output logic [A_W+B_W-1:0]    prod
);

	logic [A_W-1:0] a_q;
	logic [A_W-1:0] hi_q;
	logic [B_W-1:0] lo_q;      // multiplier bits out, product bits in
	logic [A_W:0]   sum;

	// Partial product add on the upper half only
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	// Shift-add step; done after B_W steps
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (ctl.step) begin
			hi_q <= sum[A_W:1];
			lo_q <= {sum[0], lo_q[B_W-1:1]};
		end
	end

	assign prod = {hi_q, lo_q};

endmodule

`default_nettype wire

>>> design/poi_cordic.sv
// Rotation-mode CORDIC, one iteration per step, Q2.30 cos and sin.
`timescale 1ns / 1ps
`default_nettype none

module poi_cordic import poi_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire seq_ctl_t             ctl,
	input  wire logic signed [CW-1:0] z0,
	output logic signed [CW-1:0]      cos_o,
	output logic signed [CW-1:0]      sin_o
);

	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [CW-1:0] z_q;
	logic [IDX_W-1:0]     i_q;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [CW-1:0] ang;

	// Floor shifts and table angle for this iteration
	assign xs  = x_q >>> i_q;
	assign ys  = y_q >>> i_q;
	assign ang = atan_q30(i_q);

	// Iteration index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
		end else if (ctl.load) begin
			i_q <= '0;
		end else if (ctl.step) begin
			i_q <= i_q + 1'b1;
		end
	end

	// Micro-rotation, direction from the sign of the residual angle
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= GAIN_INV_Q30;
			y_q <= '0;
			z_q <= z0;
		end else if (ctl.step) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end
		end
	end

	assign cos_o = x_q;
	assign sin_o = y_q;

endmodule

`default_nettype wire

>>> design/planar_odometry_integrator.sv
// Top level: 2D dead-reckoning pose integrator with serial multiply lanes.
//
//  channel  | direction | tdata fields (lsb first)                  | handshake
//  ---------+-----------+-------------------------------------------+----------------
//  s_*      | in        | forward_speed, side_speed, turn_rate      | tvalid/tready
//  m_*      | out       | pos_x, pos_y, heading                     | tvalid/tready
//  cfg_*    | in        | step_time                                 | cfg_we strobe
//
// A transaction runs from accept through S_LOAD, S_ROT (as long as the longer of the
// CORDIC iterations and the 16-bit first multiply pass), S_MLD, the 32 bit-steps of the
// serial lanes in S_MUL, S_SUM, S_RND and S_ACC; m_tvalid rises with the pose update.
// A new transaction is accepted while the last result still waits; it stalls only at
// its final update until that result is taken.
// Reset clears the pose to zero and loads step_time with 1311.
`timescale 1ns / 1ps
`default_nettype none

module planar_odometry_integrator import poi_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,    // forward_speed, side_speed, turn_rate
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata,    // pos_x, pos_y, heading
	input  wire logic              cfg_we,
	input  wire logic [DT_W-1:0]   cfg_wdata   // step_time
);

	localparam int ROT_LEN = (CORDIC_STEPS > DT_W) ? CORDIC_STEPS : DT_W;
	localparam int CNT_MAX = (ROT_LEN > MB_W) ? ROT_LEN : MB_W;
	localparam int CNT_W   = $clog2(CNT_MAX);
	localparam int P2_W    = 2 * MB_W;
	localparam int T_W     = P2_W + 2;
	localparam int ZP_W    = HDG_W + CW;
	localparam int DX_W    = T_W - 41;

	localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(ROT_LEN - 1);
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MB_W - 1);
	localparam logic [CNT_W-1:0] COR_END  = CNT_W'(CORDIC_STEPS);
	localparam logic [CNT_W-1:0] DT_END   = CNT_W'(DT_W);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_LOAD = 8'b0000_0010,
		S_ROT  = 8'b0000_0100,
		S_MLD  = 8'b0000_1000,
		S_MUL  = 8'b0001_0000,
		S_SUM  = 8'b0010_0000,
		S_RND  = 8'b0100_0000,
		S_ACC  = 8'b1000_0000
	} state_t;

	// Magnitude of a 16-bit signed value (-32768 maps to 32768)
	function automatic logic [V_W-1:0] mag16(input logic [V_W-1:0] v);
		return v[V_W-1] ? (~v + 1'b1) : v;
	endfunction

	// Magnitude of a CORDIC output, low MB_W bits
	function automatic logic [MB_W-1:0] magc(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] t;
		begin
			t = v[CW-1] ? -v : v;
			return t[MB_W-1:0];
		end
	endfunction

	// Signed term from sign and product magnitude
	function automatic logic signed [T_W-1:0] term(input logic neg,
			input logic [P2_W-1:0] m);
		logic signed [T_W-1:0] t;
		begin
			t = $signed({2'b00, m});
			return neg ? -t : t;
		end
	endfunction

	// Saturating accumulate of a position
	function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] acc,
			input logic signed [DX_W-1:0] d);
		logic signed [POS_W:0] s;
		begin
			s = (POS_W+1)'($signed(acc)) + (POS_W+1)'(d);
			if (s[POS_W] != s[POS_W-1])
				return s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
			return s[POS_W-1:0];
		end
	endfunction

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic              acc_fire;
	logic              s_fire;

	logic [DT_W-1:0]   step_time_q;
	logic [POS_W-1:0]  acc_x_q;
	logic [POS_W-1:0]  acc_y_q;
	logic [HDG_W-1:0]  acc_heading_q;

	logic [V_W-1:0]    fwd_q;
	logic [V_W-1:0]    side_q;
	logic [V_W-1:0]    turn_q;
	logic signed [HDG_W-1:0] h_q;
	logic              flip_q;
	logic              sc_q;
	logic              ss_q;

	logic signed [HDG_W:0]   h_ext;
	logic signed [HDG_W:0]   h_fold;
	logic                    flip_d;
	logic signed [ZP_W-1:0]  z_prod;
	logic signed [CW-1:0]    z0;
	logic signed [CW-1:0]    cor_c;
	logic signed [CW-1:0]    cor_s;

	seq_ctl_t          cor_ctl;
	seq_ctl_t          p1_ctl;
	seq_ctl_t          p2_ctl;
	logic [2*V_W-1:0]  pf;
	logic [2*V_W-1:0]  ps;
	logic [2*V_W-1:0]  pw;
	logic [P2_W-1:0]   pfc;
	logic [P2_W-1:0]   pfs;
	logic [P2_W-1:0]   psc;
	logic [P2_W-1:0]   pss;
	logic [P2_W-1:0]   pwk;

	logic signed [T_W-1:0]   xt_q;
	logic signed [T_W-1:0]   yt_q;
	logic signed [T_W-1:0]   ht_q;
	logic signed [T_W-1:0]   xr;
	logic signed [T_W-1:0]   yr;
	logic signed [T_W-1:0]   hr;
	logic signed [DX_W-1:0]  dx_q;
	logic signed [DX_W-1:0]  dy_q;
	logic [HDG_W-1:0]        dh_q;

	logic sf;
	logic sv;
	logic sw;

	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign acc_fire = (state_q == S_ACC) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {acc_heading_q, acc_y_q, acc_x_q};

	// Operand signs: side speed and turn rate are negated into the world frame
	assign sf = fwd_q[V_W-1];
	assign sv = ~side_q[V_W-1];
	assign sw = ~turn_q[V_W-1];

	// Fold the stored heading into half a turn around zero
	always_comb begin
		h_ext  = (HDG_W+1)'($signed(acc_heading_q));
		h_fold = h_ext;
		flip_d = 1'b0;
		if (h_ext > 17'sd16384) begin
			h_fold = h_ext - 17'sd32768;
			flip_d = 1'b1;
		end else if (h_ext < -17'sd16384) begin
			h_fold = h_ext + 17'sd32768;
			flip_d = 1'b1;
		end
	end

	// Binary angle to Q2.30 radians, round half up
	assign z_prod = ZP_W'(h_q) * ZP_W'(TWO_PI_Q30) + ZP_W'(32768);
	assign z0     = CW'(z_prod >>> 16);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_fire)
						state_q <= S_LOAD;
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_ROT;
				end
				S_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ROT_LAST)
						state_q <= S_MLD;
				end
				S_MLD: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == MUL_LAST)
						state_q <= S_SUM;
				end
				S_SUM: state_q <= S_RND;
				S_RND: state_q <= S_ACC;
				S_ACC: begin
					if (acc_fire)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Unit strobes
	assign cor_ctl.load = (state_q == S_LOAD);
	assign cor_ctl.step = (state_q == S_ROT) && (cnt_q < COR_END);
	assign p1_ctl.load  = (state_q == S_LOAD);
	assign p1_ctl.step  = (state_q == S_ROT) && (cnt_q < DT_END);
	assign p2_ctl.load  = (state_q == S_MLD);
	assign p2_ctl.step  = (state_q == S_MUL);

	// Step time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_time_q <= DT_W'(1311);
		else if (cfg_we)
			step_time_q <= cfg_wdata;
	end

	// Transaction capture and rotation signs
	always_ff @(posedge clk) begin
		if (s_fire) begin
			fwd_q  <= s_tdata[V_W-1:0];
			side_q <= s_tdata[2*V_W-1:V_W];
			turn_q <= s_tdata[3*V_W-1:2*V_W];
			h_q    <= HDG_W'(h_fold);
			flip_q <= flip_d;
		end
		if (state_q == S_MLD) begin
			sc_q <= cor_c[CW-1] ^ flip_q;
			ss_q <= cor_s[CW-1] ^ flip_q;
		end
	end

	poi_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cor_ctl),
		.z0     (z0),
		.cos_o  (cor_c),
		.sin_o  (cor_s)
	);

	// First pass: speeds and rate times step time
	poi_smul #(.A_W(V_W), .B_W(DT_W)) u_mul_f (
		.clk(clk), .ctl(p1_ctl), .a(mag16(fwd_q)), .b(step_time_q), .prod(pf));
	poi_smul #(.A_W(V_W), .B_W(DT_W)) u_mul_s (
		.clk(clk), .ctl(p1_ctl), .a(mag16(side_q)), .b(step_time_q), .prod(ps));
	poi_smul #(.A_W(V_W), .B_W(DT_W)) u_mul_w (
		.clk(clk), .ctl(p1_ctl), .a(mag16(turn_q)), .b(step_time_q), .prod(pw));

	// Second pass: rotation by cos/sin, rate to binary angle
	poi_smul #(.A_W(MB_W), .B_W(MB_W)) u_mul_fc (
		.clk(clk), .ctl(p2_ctl), .a(pf), .b(magc(cor_c)), .prod(pfc));
	poi_smul #(.A_W(MB_W), .B_W(MB_W)) u_mul_fs (
		.clk(clk), .ctl(p2_ctl), .a(pf), .b(magc(cor_s)), .prod(pfs));
	poi_smul #(.A_W(MB_W), .B_W(MB_W)) u_mul_sc (
		.clk(clk), .ctl(p2_ctl), .a(ps), .b(magc(cor_c)), .prod(psc));
	poi_smul #(.A_W(MB_W), .B_W(MB_W)) u_mul_ss (
		.clk(clk), .ctl(p2_ctl), .a(ps), .b(magc(cor_s)), .prod(pss));
	poi_smul #(.A_W(MB_W), .B_W(MB_W)) u_mul_wk (
		.clk(clk), .ctl(p2_ctl), .a(pw), .b(RAD_TO_BAM_Q32), .prod(pwk));

	// Rounding adds
	assign xr = xt_q + (T_W'(1) <<< 41);
	assign yr = yt_q + (T_W'(1) <<< 41);
	assign hr = ht_q + (T_W'(1) <<< 43);

	// Combine terms, round, then update the pose
	always_ff @(posedge clk) begin
		if (state_q == S_SUM) begin
			xt_q <= term(sf ^ sc_q, pfc) + term(~(sv ^ ss_q), pss);
			yt_q <= term(sf ^ ss_q, pfs) + term(sv ^ sc_q, psc);
			ht_q <= term(sw, pwk);
		end
		if (state_q == S_RND) begin
			dx_q <= DX_W'(xr >>> 42);
			dy_q <= DX_W'(yr >>> 42);
			dh_q <= HDG_W'(hr >>> 44);
		end
	end

	// Pose state doubles as the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q       <= '0;
			acc_y_q       <= '0;
			acc_heading_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (acc_fire) begin
				acc_x_q       <= sat_add(acc_x_q, dx_q);
				acc_y_q       <= sat_add(acc_y_q, dy_q);
				acc_heading_q <= acc_heading_q + dh_q;
				out_valid_q   <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/poi_checker.sv
// Port-level checks of the pose integrator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "planar_odometry_integrator_defines.svh"

module poi_checker import poi_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	// A stalled result holds
	`POI_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

	// One transaction at a time
	`POI_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted twice in a row")

	// A result never follows its transaction in the next cycle
	`POI_ASSERT_NXT(a_no_early_result, s_tvalid && s_tready, $stable(m_tdata), "pose moved right after accept")

	// The pose only changes when a new result is shown
	`POI_ASSERT_NXT(a_data_with_valid, !m_tvalid, m_tvalid || $stable(m_tdata), "pose changed without a result")

	// Finishing a transaction frees the input side
	`POI_ASSERT_IMP(a_ready_on_result, $rose(m_tvalid), s_tready, "input not ready after result")

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for the pose integrator: streamed speed commands, predicted poses.
`timescale 1ns / 1ps

module tb;
	import poi_pkg::*;

	localparam int TRIG_ITERS = 16;
	localparam int ITEM_LATENCY = TRIG_ITERS + 38;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int IDLE_PCT = 37;
	localparam int CRUISE_RUN = 16;
	localparam logic [DT_W-1:0] DT_RESET = 16'd1311;
	localparam longint INV_GAIN = 64'sd652032874;
	localparam longint TURN_Q30 = 64'sd6746518852;
	localparam longint RAD_TO_ANGLE = 64'sd683565276;
	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint POS_MIN = -64'sd2147483648;
	localparam logic [15:0] V_MAX = 16'h7fff;
	localparam logic [15:0] V_MIN = 16'h8000;

	typedef struct {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [HDG_W-1:0]        hdg;
	} pose_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;    // forward_speed, side_speed, turn_rate
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;         // pos_x, pos_y, heading
	logic                cfg_we = 1'b0;
	logic [DT_W-1:0]     cfg_wdata = '0;  // step_time

	// Predicted block state
	logic [DT_W-1:0]         dt_model = DT_RESET;
	logic signed [POS_W-1:0] x_model = '0;
	logic signed [POS_W-1:0] y_model = '0;
	logic [HDG_W-1:0]        hdg_model = '0;

	logic [IN_W-1:0] cmd_q[$];
	pose_t           pose_q[$];
	int              errors = 0;
	int              cycles = 0;
	bit              steady = 1'b0;

	planar_odometry_integrator #(.CORDIC_STEPS(TRIG_ITERS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// atan(2^-i), Q2.30
	function automatic longint arctan_q30(input int i);
		case (i)
			0: return 843314857;
			1: return 497837829;
			2: return 263043837;
			3: return 133525159;
			4: return 67021687;
			5: return 33543516;
			6: return 16775851;
			7: return 8388437;
			8: return 4194283;
			9: return 2097149;
			10: return 1048576;
			11: return 524288;
			12: return 262144;
			13: return 131072;
			14: return 65536;
			15: return 32768;
			16: return 16384;
			17: return 8192;
			18: return 4096;
			19: return 2048;
			20: return 1024;
			21: return 512;
			22: return 256;
			default: return 128;
		endcase
	endfunction

	// Rotation-mode CORDIC on a binary angle; cos and sin in Q2.30
	function automatic void heading_trig(input logic [HDG_W-1:0] ang,
			output longint cos_v, output longint sin_v);
		longint h, x, y, z, xs, ys;
		bit flip;
		int i;
		h = longint'($signed(ang));
		flip = 1'b0;
		// fold into the right half plane, negate the vector afterwards
		if (h > 16384) begin
			h = h - 32768;
			flip = 1'b1;
		end else if (h < -16384) begin
			h = h + 32768;
			flip = 1'b1;
		end
		z = (h * TURN_Q30 + 64'sd32768) >>> 16;
		x = INV_GAIN;
		y = 0;
		for (i = 0; i < TRIG_ITERS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - arctan_q30(i);
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + arctan_q30(i);
			end
		end
		cos_v = flip ? -x : x;
		sin_v = flip ? -y : y;
	endfunction

	// One dead-reckoning step; queues the pose the block must report
	function automatic void integrate_command(input logic [IN_W-1:0] cmd);
		longint fwd, side, yaw, dt, c, s, xd, yd, nx, ny, dh;
		pose_t p;
		fwd = longint'($signed(cmd[15:0]));
		side = -longint'($signed(cmd[31:16]));
		yaw = -longint'($signed(cmd[47:32]));
		dt = longint'(dt_model);
		heading_trig(hdg_model, c, s);
		xd = fwd * c - side * s;
		yd = fwd * s + side * c;
		nx = longint'(x_model) + ((xd * dt + (64'sd1 << 41)) >>> 42);
		ny = longint'(y_model) + ((yd * dt + (64'sd1 << 41)) >>> 42);
		x_model = (nx > POS_MAX) ? 32'sh7fffffff : (nx < POS_MIN) ? 32'sh80000000 : nx[31:0];
		y_model = (ny > POS_MAX) ? 32'sh7fffffff : (ny < POS_MIN) ? 32'sh80000000 : ny[31:0];
		dh = (yaw * dt * RAD_TO_ANGLE + (64'sd1 << 43)) >>> 44;
		hdg_model = hdg_model + dh[15:0];
		p.x = x_model;
		p.y = y_model;
		p.hdg = hdg_model;
		pose_q.insert(pose_q.size(), p);
	endfunction

	function automatic void compare_pose(input logic [OUT_W-1:0] got);
		pose_t want;
		if (pose_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected pose, expected none, got x=%0d y=%0d heading=%0d",
				$time, $signed(got[31:0]), $signed(got[63:32]), got[79:64]);
			return;
		end
		want = pose_q.pop_front();
		if (got[31:0] !== want.x) begin
			errors++;
			$display("%0t: pos_x expected %0d, got %0d", $time, want.x, $signed(got[31:0]));
		end
		if (got[63:32] !== want.y) begin
			errors++;
			$display("%0t: pos_y expected %0d, got %0d", $time, want.y, $signed(got[63:32]));
		end
		if (got[79:64] !== want.hdg) begin
			errors++;
			$display("%0t: heading expected %0d, got %0d", $time, want.hdg, got[79:64]);
		end
	endfunction

	function automatic logic [IN_W-1:0] command(input logic [15:0] fwd,
			input logic [15:0] side, input logic [15:0] turn);
		return {turn, side, fwd};
	endfunction

	// Append a command to the driver queue
	function automatic void put_cmd(input logic [IN_W-1:0] cmd);
		cmd_q.insert(cmd_q.size(), cmd);
	endfunction

	// Mostly uniform, with the field extremes mixed in
	function automatic logic [15:0] pick_value();
		case ($urandom_range(7))
			0: return V_MIN;
			1: return V_MAX;
			2: return $urandom_range(1) ? 16'h0000 : 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_commands(input int n);
		int i;
		for (i = 0; i < n; i++)
			put_cmd(command(pick_value(), pick_value(), pick_value()));
	endtask

	// Nothing queued, nothing offered, nothing outstanding
	task automatic wait_idle();
		do @(negedge clk); while (cmd_q.size() != 0 || s_tvalid || pose_q.size() != 0);
	endtask

	task automatic set_step_time(input logic [DT_W-1:0] v);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		dt_model = v;
	endtask

	// Command driver: offers queued commands, predicts the pose on each transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				integrate_command(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (cmd_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					s_tvalid <= 1'b1;
					s_tdata <= cmd_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Pose monitor with random back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				compare_pose(m_tdata);
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("planar_odometry_integrator verification failed");
			$finish;
		end
	end

	initial begin
		longint h_s, t_steer;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default step time: speed and rate extremes
		put_cmd(command(16'h0000, 16'h0000, 16'h0000));
		put_cmd(command(V_MAX, 16'h0000, 16'h0000));
		put_cmd(command(V_MIN, 16'h0000, 16'h0000));
		put_cmd(command(16'h0000, V_MAX, 16'h0000));
		put_cmd(command(16'h0000, V_MIN, 16'h0000));
		put_cmd(command(16'h0000, 16'h0000, V_MAX));
		put_cmd(command(16'h0000, 16'h0000, V_MIN));
		put_cmd(command(V_MAX, V_MAX, V_MAX));
		put_cmd(command(V_MIN, V_MIN, V_MIN));

		// longest step: heading steps beyond a full turn wrap
		set_step_time(16'hffff);
		put_cmd(command(16'h0000, 16'h0000, V_MIN));
		put_cmd(command(16'h0000, 16'h0000, V_MAX));
		put_cmd(command(V_MIN, V_MIN, 16'h0000));
		put_cmd(command(V_MAX, V_MAX, 16'h4000));
		put_cmd(command(V_MAX, 16'h0000, 16'h8000));
		put_cmd(command(V_MAX, V_MIN, V_MAX));

		// zero step: pose holds
		set_step_time(16'h0000);
		put_cmd(command(V_MIN, V_MIN, V_MIN));
		put_cmd(command(V_MAX, 16'h0000, V_MAX));

		// shortest nonzero step
		set_step_time(16'h0001);
		put_cmd(command(V_MAX, V_MAX, V_MAX));
		put_cmd(command(V_MIN, V_MIN, V_MIN));

		// random commands over several step times
		set_step_time(DT_RESET);
		random_commands(90);
		set_step_time(16'($urandom));
		random_commands(90);
		set_step_time(16'hffff);
		steady = 1'b1;
		random_commands(90);
		wait_idle();
		steady = 1'b0;
		set_step_time(16'($urandom_range(1, 4095)));
		random_commands(90);

		// steer heading near zero, run straight at full speed, then reverse
		set_step_time(16'hffff);
		wait_idle();
		h_s = longint'($signed(hdg_model));
		t_steer = (h_s * (64'sd1 << 44)) / (64'sd65535 * RAD_TO_ANGLE);
		put_cmd(command(16'h0000, 16'h0000, t_steer[15:0]));
		repeat (CRUISE_RUN) put_cmd(command(V_MAX, V_MAX, 16'h0000));
		repeat (5) put_cmd(command(V_MIN, V_MIN, 16'h0000));

		wait_idle();
		repeat (ITEM_LATENCY) @(posedge clk);
		if (errors == 0 && pose_q.size() == 0)
			$display("planar_odometry_integrator verification clean");
		else
			$display("planar_odometry_integrator verification failed");
		$finish;
	end

endmodule
